### hw/rtl/bid_pkg.sv
package bid_pkg;

    // table size and the part of it that a 5-bit slot can reach
    localparam int NUM_SECTORS = 32;
    localparam int SLOT_LIMIT  = 32;
    localparam int TABLE_DEPTH = (NUM_SECTORS < SLOT_LIMIT) ? NUM_SECTORS : SLOT_LIMIT;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int SECTOR_W  = 5;
    localparam int MOD_W     = 8;
    localparam int LAY_W     = 4;
    localparam int BARS_W    = 8;
    localparam int BAR_IDX_W = 16;

    // arithmetic widths
    localparam int PM_W   = MOD_W + LAY_W;       // bars per module
    localparam int TOT_W  = PM_W + MOD_W;        // bars per sector
    localparam int END_W  = TOT_W + 1;           // first + total, unwrapped
    localparam int DIVD_W = BAR_IDX_W;
    localparam int DIVS_W = PM_W;

    // stream widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 32;

    // item kinds carried in tuser
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic [BAR_IDX_W-1:0] first_bar;
        logic [BARS_W-1:0]    bars_per_layer;
        logic [LAY_W-1:0]     layer_count;
        logic [MOD_W-1:0]     module_count;
    } entry_t;

endpackage

### hw/rtl/bid_sector_table.sv
module bid_sector_table
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [bid_pkg::SLOT_W-1:0] wr_addr,
    input  bid_pkg::entry_t           wr_data,
    input  logic [bid_pkg::SLOT_W-1:0] rd_addr,
    output bid_pkg::entry_t           rd_data
);

    bid_pkg::entry_t                   mem [bid_pkg::TABLE_DEPTH];
    bid_pkg::entry_t                   rd_data_reg;
    logic [bid_pkg::TABLE_DEPTH-1:0]   valid_reg;
    logic                              rd_valid_reg;

    // entry storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // per-entry valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // an entry never written reads as empty
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### hw/rtl/bid_divider.sv
module bid_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bid_pkg::DIVD_W-1:0] dividend,
    input  logic [bid_pkg::DIVS_W-1:0] divisor,
    output logic                       done,
    output logic [bid_pkg::DIVD_W-1:0] quotient,
    output logic [bid_pkg::DIVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(bid_pkg::DIVD_W + 1);

    logic [bid_pkg::DIVS_W-1:0] rem_reg;
    logic [bid_pkg::DIVS_W-1:0] rem_next;
    logic [bid_pkg::DIVD_W-1:0] quo_reg;
    logic [bid_pkg::DIVD_W-1:0] quo_next;
    logic [bid_pkg::DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       done_reg;
    logic [bid_pkg::DIVS_W:0]   trial;
    logic [bid_pkg::DIVS_W:0]   diff;
    logic                       ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[bid_pkg::DIVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[bid_pkg::DIVS_W-1:0] : trial[bid_pkg::DIVS_W-1:0];
        quo_next = {quo_reg[bid_pkg::DIVD_W-2:0], ge};
    end

    // one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
            cnt_reg  <= CNT_W'(bid_pkg::DIVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hw/rtl/bar_index_decomposer_unit.sv
// Bar index decomposer. A write transfer (tuser 0) stores one sector entry
// and gives no result. A lookup transfer (tuser 1) walks the sector table
// from entry 0 through a pipelined read of the table memory, one entry per
// cycle, and stops at the first sector whose range holds the bar index.
// The offset inside that sector is split into module, layer and bar by a
// shared one-bit-per-cycle divider, used twice. A lookup that matches goes
// through the walk, the module division, the layer division (each a start,
// one restoring step per dividend bit and a done) and the load of the output
// register before it returns to idle; one that matches nothing walks every
// entry and goes straight to the output register.
// A result stuck in a full output register holds the lookup until the
// receiver takes it. One lookup is worked on at a time; the result sits in
// an output register so the next item is taken while it waits. The table is
// empty after reset and entries never written never match.
module bar_index_decomposer_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sector_slot, module_count, layer_count, bars_per_layer, first_bar, bar_index
    input  logic [bid_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // action
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sector, module_res, layer, bar
    output logic [bid_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // found
    output logic                           m_axis_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV_MOD,
        ST_DIV_LAYER,
        ST_RESULT
    } state_t;

    localparam int RES_W = bid_pkg::SECTOR_W + bid_pkg::MOD_W + bid_pkg::LAY_W
                         + bid_pkg::BARS_W;

    // input fields
    logic [bid_pkg::SECTOR_W-1:0]  in_slot;
    logic [bid_pkg::BAR_IDX_W-1:0] in_bar_index;
    bid_pkg::entry_t               in_entry;
    logic                          in_xfer;
    logic                          slot_ok;
    logic                          tbl_wr_en;

    // control and pipeline registers
    state_t                        state_reg, state_next;
    logic [bid_pkg::PTR_W-1:0]     issue_ptr_reg, issue_ptr_next;
    logic [bid_pkg::BAR_IDX_W-1:0] idx_reg, idx_next;
    logic                          p1_vld_reg, p1_vld_next;
    logic [bid_pkg::SLOT_W-1:0]    p1_idx_reg, p1_idx_next;
    logic                          p2_vld_reg, p2_vld_next;
    logic [bid_pkg::SLOT_W-1:0]    p2_idx_reg, p2_idx_next;
    logic [bid_pkg::PM_W-1:0]      p2_pm_reg, p2_pm_next;
    logic [bid_pkg::MOD_W-1:0]     p2_mod_reg, p2_mod_next;
    logic [bid_pkg::BARS_W-1:0]    p2_bars_reg, p2_bars_next;
    logic [bid_pkg::BAR_IDX_W-1:0] p2_first_reg, p2_first_next;

    // result assembly and divider operands
    logic                          found_reg, found_next;
    logic [bid_pkg::SECTOR_W-1:0]  sector_reg, sector_next;
    logic [bid_pkg::MOD_W-1:0]     mod_reg, mod_next;
    logic [bid_pkg::LAY_W-1:0]     layer_reg, layer_next;
    logic [bid_pkg::BARS_W-1:0]    bar_reg, bar_next;
    logic [bid_pkg::BARS_W-1:0]    bars_reg, bars_next;
    logic                          div_start_reg, div_start_next;
    logic [bid_pkg::DIVD_W-1:0]    dividend_reg, dividend_next;
    logic [bid_pkg::DIVS_W-1:0]    divisor_reg, divisor_next;

    // output register
    logic                          m_vld_reg, m_vld_next;
    logic [bid_pkg::M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic                          m_user_reg, m_user_next;

    // table, divider and match logic
    logic [bid_pkg::SLOT_W-1:0]    rd_addr;
    bid_pkg::entry_t               tbl_rd;
    logic                          issuing;
    logic [bid_pkg::TOT_W-1:0]     total;
    logic [bid_pkg::END_W-1:0]     span_end;
    logic                          hit;
    logic                          walk_last;
    logic [bid_pkg::BAR_IDX_W-1:0] loc;
    logic                          res_ready;
    logic                          div_done;
    logic [bid_pkg::DIVD_W-1:0]    div_quot;
    logic [bid_pkg::DIVS_W-1:0]    div_rem;

    // unpack the input transfer
    assign in_slot                 = s_axis_tdata[4:0];
    assign in_entry.module_count   = s_axis_tdata[12:5];
    assign in_entry.layer_count    = s_axis_tdata[16:13];
    assign in_entry.bars_per_layer = s_axis_tdata[24:17];
    assign in_entry.first_bar      = s_axis_tdata[40:25];
    assign in_bar_index            = s_axis_tdata[56:41];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign slot_ok       = (32'(in_slot) < bid_pkg::TABLE_DEPTH);
    assign tbl_wr_en     = in_xfer && (s_axis_tuser == bid_pkg::ACT_WRITE) && slot_ok;

    bid_sector_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (in_slot[bid_pkg::SLOT_W-1:0]),
        .wr_data (in_entry),
        .rd_addr (rd_addr),
        .rd_data (tbl_rd)
    );

    bid_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (dividend_reg),
        .divisor   (divisor_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // walk pointer and range check on the second pipeline stage
    assign issuing   = (state_reg == ST_WALK) &&
                       (issue_ptr_reg < bid_pkg::PTR_W'(bid_pkg::TABLE_DEPTH));
    assign rd_addr   = issue_ptr_reg[bid_pkg::SLOT_W-1:0];
    assign total     = bid_pkg::TOT_W'(p2_pm_reg) * bid_pkg::TOT_W'(p2_mod_reg);
    assign span_end  = bid_pkg::END_W'(p2_first_reg) + bid_pkg::END_W'(total);
    assign hit       = (state_reg == ST_WALK) && p2_vld_reg && (total != '0) &&
                       (idx_reg >= p2_first_reg) &&
                       (bid_pkg::END_W'(idx_reg) < span_end);
    assign walk_last = (state_reg == ST_WALK) && p2_vld_reg &&
                       (p2_idx_reg == bid_pkg::SLOT_W'(bid_pkg::TABLE_DEPTH - 1));
    assign loc       = idx_reg - p2_first_reg;
    assign res_ready = !m_vld_reg || m_axis_tready;

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        issue_ptr_next = issue_ptr_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        sector_next    = sector_reg;
        mod_next       = mod_reg;
        layer_next     = layer_reg;
        bar_next       = bar_reg;
        bars_next      = bars_reg;
        div_start_next = 1'b0;
        dividend_next  = dividend_reg;
        divisor_next   = divisor_reg;
        m_vld_next     = m_vld_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        // read pipeline: stage one waits on the memory, stage two multiplies
        p1_vld_next   = issuing && !hit;
        p1_idx_next   = rd_addr;
        p2_vld_next   = p1_vld_reg && (state_reg == ST_WALK) && !hit;
        p2_idx_next   = p1_idx_reg;
        p2_pm_next    = bid_pkg::PM_W'(tbl_rd.bars_per_layer) *
                        bid_pkg::PM_W'(tbl_rd.layer_count);
        p2_mod_next   = tbl_rd.module_count;
        p2_bars_next  = tbl_rd.bars_per_layer;
        p2_first_next = tbl_rd.first_bar;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (s_axis_tuser == bid_pkg::ACT_LOOKUP))
                begin
                    state_next     = ST_WALK;
                    issue_ptr_next = '0;
                    idx_next       = in_bar_index;
                end
            end
            ST_WALK:
            begin
                if (issuing)
                begin
                    issue_ptr_next = issue_ptr_reg + bid_pkg::PTR_W'(1);
                end
                if (hit)
                begin
                    state_next     = ST_DIV_MOD;
                    found_next     = 1'b1;
                    sector_next    = bid_pkg::SECTOR_W'(p2_idx_reg);
                    bars_next      = p2_bars_reg;
                    div_start_next = 1'b1;
                    dividend_next  = loc;
                    divisor_next   = p2_pm_reg;
                end
                else if (walk_last)
                begin
                    state_next  = ST_RESULT;
                    found_next  = 1'b0;
                    sector_next = '0;
                    mod_next    = '0;
                    layer_next  = '0;
                    bar_next    = '0;
                end
            end
            ST_DIV_MOD:
            begin
                if (div_done)
                begin
                    state_next     = ST_DIV_LAYER;
                    mod_next       = div_quot[bid_pkg::MOD_W-1:0];
                    div_start_next = 1'b1;
                    dividend_next  = bid_pkg::DIVD_W'(div_rem);
                    divisor_next   = bid_pkg::DIVS_W'(bars_reg);
                end
            end
            ST_DIV_LAYER:
            begin
                if (div_done)
                begin
                    state_next = ST_RESULT;
                    layer_next = div_quot[bid_pkg::LAY_W-1:0];
                    bar_next   = div_rem[bid_pkg::BARS_W-1:0];
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next  = ST_IDLE;
                    m_vld_next  = 1'b1;
                    m_user_next = found_reg;
                    m_data_next = bid_pkg::M_DATA_W'({bar_reg, layer_reg, mod_reg,
                                                     sector_reg});
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_ptr_reg <= '0;
            idx_reg       <= '0;
            p1_vld_reg    <= 1'b0;
            p1_idx_reg    <= '0;
            p2_vld_reg    <= 1'b0;
            p2_idx_reg    <= '0;
            p2_pm_reg     <= '0;
            p2_mod_reg    <= '0;
            p2_bars_reg   <= '0;
            p2_first_reg  <= '0;
            found_reg     <= 1'b0;
            sector_reg    <= '0;
            mod_reg       <= '0;
            layer_reg     <= '0;
            bar_reg       <= '0;
            bars_reg      <= '0;
            div_start_reg <= 1'b0;
            dividend_reg  <= '0;
            divisor_reg   <= '0;
            m_vld_reg     <= 1'b0;
            m_data_reg    <= '0;
            m_user_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_ptr_reg <= issue_ptr_next;
            idx_reg       <= idx_next;
            p1_vld_reg    <= p1_vld_next;
            p1_idx_reg    <= p1_idx_next;
            p2_vld_reg    <= p2_vld_next;
            p2_idx_reg    <= p2_idx_next;
            p2_pm_reg     <= p2_pm_next;
            p2_mod_reg    <= p2_mod_next;
            p2_bars_reg   <= p2_bars_next;
            p2_first_reg  <= p2_first_next;
            found_reg     <= found_next;
            sector_reg    <= sector_next;
            mod_reg       <= mod_next;
            layer_reg     <= layer_next;
            bar_reg       <= bar_next;
            bars_reg      <= bars_next;
            div_start_reg <= div_start_next;
            dividend_reg  <= dividend_next;
            divisor_reg   <= divisor_next;
            m_vld_reg     <= m_vld_next;
            m_data_reg    <= m_data_next;
            m_user_reg    <= m_user_next;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[RES_W-1:0] == '0))
        else $error("miss result with nonzero fields");

    // divider finishes only while a decomposition is running
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_MOD || state_reg == ST_DIV_LAYER))
        else $error("divider done outside a division state");

    // module quotient fits its field since the offset lies below the sector size
    a_mod_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (div_done && state_reg == ST_DIV_MOD) |->
        (div_quot[bid_pkg::DIVD_W-1:bid_pkg::MOD_W] == '0))
        else $error("module quotient overflow");

    // layer quotient fits its field since the remainder lies below bars per module
    a_layer_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (div_done && state_reg == ST_DIV_LAYER) |->
        (div_quot[bid_pkg::DIVD_W-1:bid_pkg::LAY_W] == '0))
        else $error("layer quotient overflow");

    // a lookup transfer starts the table walk
    a_lookup_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> (state_reg == ST_WALK))
        else $error("lookup did not start a walk");

endmodule
